>>> design/nlc_pkg.sv
// Package for the normalized line convolution core: sizes, register
// indexes and the sequencer state type. No dependencies.
package nlc_pkg;

  localparam int unsigned MAX_RADIUS   = 3;
  localparam int unsigned PIXEL_BITS   = 12;
  localparam int unsigned TAP_BITS     = 8;
  localparam int unsigned RADIUS_BITS  = 2;
  localparam int unsigned WIN_DEPTH    = 2 * MAX_RADIUS + 1;
  localparam int unsigned AGE_BITS     = $clog2(WIN_DEPTH);
  localparam int unsigned POS_BITS     = $clog2(WIN_DEPTH + 1);
  localparam int unsigned TAP_IDX_BITS = (MAX_RADIUS > 0) ? $clog2(MAX_RADIUS + 1) : 1;
  localparam int unsigned WSUM_BITS    = TAP_BITS + $clog2(WIN_DEPTH);
  localparam int unsigned ACC_BITS     = PIXEL_BITS + WSUM_BITS;
  localparam int unsigned DIV_CNT_BITS = $clog2(PIXEL_BITS);
  localparam int unsigned TDATA_BITS   = ((PIXEL_BITS + 7) / 8) * 8;
  localparam int unsigned CFG_IDX_BITS = 3;
  localparam int unsigned CFG_DATA_BITS = 8;

  // Configuration register indexes
  localparam logic [CFG_IDX_BITS-1:0] REG_KERNEL_RADIUS = 3'd0;
  localparam logic [CFG_IDX_BITS-1:0] REG_TAP_CENTER    = 3'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DIV,
    ST_EMIT
  } nlc_state_e;

endpackage

>>> design/normalized_line_convolution_core.sv
// Normalized line convolution core: streaming symmetric line filter with
// border renormalization, bit-serial restoring divider.
// Depends on nlc_pkg.
//
// Usage:
//   s_axis carries pixels of one line in order, tlast on the last pixel.
//   m_axis carries filtered pixels, tlast on the final one of each line.
//   The cfg channel writes kernel_radius (index 0) and the taps (index 1 for
//   the center, then one per distance); it is always ready and is meant to be
//   written only while the core is idle.
// Flow: each result runs a multiply-accumulate pass over the window ages,
//   then the restoring divide, then a load of the output register.
//   A mid-line pixel yields at most one result, a line-end pixel up to
//   radius+1 results; no new pixel is taken until an item is through.
//   The MAC uses a single shared multiplier; the divider makes one bit per cycle.
//   Results trail the input by radius pixels; the line-end pixel flushes.
// Reset: registers return to radius 1 and all taps 1, window and line count
//   clear. A stalled receiver holds the output register; the core accepts
//   the next pixel meanwhile and waits before loading a new result.
module normalized_line_convolution_core
  import nlc_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // s_axis_tdata: [11:0] pixel_value, rest zero
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [TDATA_BITS-1:0]    s_axis_tdata,
  input  logic                     s_axis_tlast,
  // m_axis_tdata: [11:0] filtered_value, rest zero
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [TDATA_BITS-1:0]    m_axis_tdata,
  output logic                     m_axis_tlast,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  nlc_state_e state_q, state_d;

  logic [RADIUS_BITS-1:0]  radius_q;
  logic [TAP_BITS-1:0]     taps_q [MAX_RADIUS+1];
  logic [PIXEL_BITS-1:0]   window_q [WIN_DEPTH];
  logic [POS_BITS-1:0]     line_pos_q;
  logic [POS_BITS-1:0]     item_n_q;
  logic                    item_last_q;
  logic [AGE_BITS-1:0]     cur_c_q;
  logic [AGE_BITS-1:0]     age_q;
  logic [ACC_BITS-1:0]     acc_q;
  logic [WSUM_BITS-1:0]    wsum_q;
  logic [WSUM_BITS-1:0]    rem_q;
  logic [PIXEL_BITS-1:0]   quo_q;
  logic [DIV_CNT_BITS-1:0] div_cnt_q;
  logic                    out_valid_q;
  logic [PIXEL_BITS-1:0]   out_data_q;
  logic                    out_last_q;

  logic                    in_fire;
  logic                    out_fire;
  logic                    start_item;
  logic [AGE_BITS-1:0]     r_eff;
  logic [AGE_BITS-1:0]     start_c;
  logic [AGE_BITS-1:0]     tap_dist;
  logic [TAP_BITS-1:0]     tap;
  logic                    use_age;
  logic [ACC_BITS-1:0]     acc_next;
  logic [WSUM_BITS-1:0]    wsum_next;
  logic                    mac_done;
  logic [WSUM_BITS+1:0]    trial;
  logic                    div_done;
  logic                    out_free;
  logic                    more_results;

  assign in_fire    = s_axis_tvalid && s_axis_tready;
  assign out_fire   = m_axis_tvalid && m_axis_tready;
  assign cfg_ready_o = 1'b1;

  assign r_eff = (radius_q > RADIUS_BITS'(MAX_RADIUS)) ? AGE_BITS'(MAX_RADIUS)
                                                       : AGE_BITS'(radius_q);

  // Item control: which center to filter first and whether to filter at all
  always_comb begin
    start_item = 1'b0;
    start_c    = r_eff;
    if (in_fire) begin
      if (s_axis_tlast) begin
        start_item = 1'b1;
        start_c    = (POS_BITS'(r_eff) > line_pos_q) ? AGE_BITS'(line_pos_q) : r_eff;
      end else if (line_pos_q >= POS_BITS'(r_eff)) begin
        start_item = 1'b1;
      end
    end
  end

  // Multiply-accumulate over window ages, one age per cycle
  always_comb begin
    tap_dist = (age_q >= cur_c_q) ? age_q - cur_c_q : cur_c_q - age_q;
    tap  = (tap_dist <= AGE_BITS'(MAX_RADIUS)) ? taps_q[TAP_IDX_BITS'(tap_dist)] : '0;
    use_age = ({1'b0, age_q} <= ({1'b0, cur_c_q} + {1'b0, r_eff}))
           && (POS_BITS'(age_q) <= item_n_q)
           && (({1'b0, age_q} + {1'b0, r_eff}) >= {1'b0, cur_c_q});
    acc_next  = acc_q;
    wsum_next = wsum_q;
    if (use_age) begin
      acc_next  = acc_q + ACC_BITS'(window_q[age_q]) * ACC_BITS'(tap);
      wsum_next = wsum_q + WSUM_BITS'(tap);
    end
    mac_done = (age_q == AGE_BITS'(WIN_DEPTH - 1));
  end

  // Restoring division: the quotient fits PIXEL_BITS, so the upper bits
  // of the dividend preload the partial remainder
  always_comb begin
    trial    = {1'b0, rem_q, quo_q[PIXEL_BITS-1]} - {2'b00, wsum_q};
    div_done = (div_cnt_q == DIV_CNT_BITS'(PIXEL_BITS - 1));
  end

  assign out_free     = !out_valid_q || m_axis_tready;
  assign more_results = item_last_q && (cur_c_q != '0);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (start_item) state_d = ST_MAC;
      ST_MAC:  if (mac_done) state_d = ST_DIV;
      ST_DIV:  if (div_done) state_d = ST_EMIT;
      ST_EMIT: begin
        if (out_free) state_d = more_results ? ST_MAC : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    m_axis_tvalid = out_valid_q;
    m_axis_tdata  = TDATA_BITS'(out_data_q);
    m_axis_tlast  = out_last_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      radius_q    <= RADIUS_BITS'(1);
      for (int k = 0; k <= MAX_RADIUS; k++) taps_q[k] <= TAP_BITS'(1);
      for (int k = 0; k < WIN_DEPTH; k++) window_q[k] <= '0;
      line_pos_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == REG_KERNEL_RADIUS) radius_q <= cfg_data_i[RADIUS_BITS-1:0];
        for (int k = 0; k <= MAX_RADIUS; k++) begin
          if (cfg_index_i == REG_TAP_CENTER + CFG_IDX_BITS'(k))
            taps_q[k] <= cfg_data_i[TAP_BITS-1:0];
        end
      end

      if (in_fire) begin
        for (int k = WIN_DEPTH - 1; k > 0; k--) window_q[k] <= window_q[k-1];
        window_q[0] <= s_axis_tdata[PIXEL_BITS-1:0];
        if (s_axis_tlast) begin
          line_pos_q <= '0;
        end else if (line_pos_q != POS_BITS'(WIN_DEPTH)) begin
          line_pos_q <= line_pos_q + POS_BITS'(1);
        end
      end

      // Load takes priority over the drain of the same cycle
      if (state_q == ST_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_fire) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        item_n_q    <= line_pos_q;
        item_last_q <= s_axis_tlast;
        cur_c_q     <= start_c;
        age_q       <= '0;
        acc_q       <= '0;
        wsum_q      <= '0;
      end
      ST_MAC: begin
        acc_q  <= acc_next;
        wsum_q <= wsum_next;
        age_q  <= age_q + AGE_BITS'(1);
        if (mac_done) begin
          rem_q     <= acc_next[ACC_BITS-1:PIXEL_BITS];
          quo_q     <= acc_next[PIXEL_BITS-1:0];
          div_cnt_q <= '0;
        end
      end
      ST_DIV: begin
        div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
        if (!trial[WSUM_BITS+1]) begin
          rem_q <= trial[WSUM_BITS-1:0];
          quo_q <= {quo_q[PIXEL_BITS-2:0], 1'b1};
        end else begin
          rem_q <= {rem_q[WSUM_BITS-2:0], quo_q[PIXEL_BITS-1]};
          quo_q <= {quo_q[PIXEL_BITS-2:0], 1'b0};
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          out_data_q <= (wsum_q == '0) ? '0 : quo_q;
          out_last_q <= item_last_q && (cur_c_q == '0);
          // Step to the next newer center of the flush
          cur_c_q    <= cur_c_q - AGE_BITS'(more_results);
          age_q      <= '0;
          acc_q      <= '0;
          wsum_q     <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule
